// ----- rtl/mppd_pkg.sv -----
// Package for the median-edge predictive pixel decoder.
// Holds register codes, field widths, reset values and the median helper.
// No dependencies.
package mppd_pkg;

  // Configuration field widths
  localparam int CFG_MODE_W = 2;
  localparam int CFG_LEN_W  = 9;
  localparam int CFG_CNT_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Pixel byte width
  localparam int PIX_W = 8;

  // Default sizes
  localparam int DEF_MAX_COLUMN_LENGTH = 256;
  localparam int DEF_MAX_COLUMNS       = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd2;

  // Decode modes (code 3 is treated as intra)
  localparam logic [CFG_MODE_W-1:0] MODE_INTRA  = 2'd0;
  localparam logic [CFG_MODE_W-1:0] MODE_DIFF   = 2'd1;
  localparam logic [CFG_MODE_W-1:0] MODE_SELECT = 2'd2;

  // Register reset values
  localparam logic [CFG_LEN_W-1:0] RST_COLUMN_LENGTH = 9'd240;
  localparam logic [CFG_CNT_W-1:0] RST_COLUMN_COUNT  = 11'd400;

  typedef logic [PIX_W-1:0] pix_t;

  // Median of three bytes
  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    pix_t hi;
    pix_t lo;
    pix_t res;
    hi = (a > b) ? a : b;
    lo = (a < b) ? a : b;
    if (c >= hi) begin
      res = hi;
    end else if (c <= lo) begin
      res = lo;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ----- rtl/med_predictive_pixel_decoder_top.sv -----
// Pipeline: memory read into stage 1, then predict and write back into the output register.
// Throughput: one pixel per cycle while out_tready holds; the column history RAM has one read and one write port,
// and a same-entry read during write back is forwarded from the pixel being written.
// Reset (rst_n low, synchronous): scan position, neighbor registers and valids clear,
// registers return to intra mode, length 240, count 400. The history RAM is not cleared.
// Top level of the median-edge predictive pixel decoder; depends on mppd_pkg.
module med_predictive_pixel_decoder_top #(
  parameter int MAX_COLUMN_LENGTH = mppd_pkg::DEF_MAX_COLUMN_LENGTH,
  parameter int MAX_COLUMNS       = mppd_pkg::DEF_MAX_COLUMNS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [7:0] residual, [15:8] previous_pixel
  input  logic                            in_tuser,   // [0] use_difference
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] pixel
  output logic                            out_tlast,  // end_of_frame
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mppd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mppd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mppd_pkg::*;

  localparam int RW  = (MAX_COLUMN_LENGTH > 1) ? $clog2(MAX_COLUMN_LENGTH) : 1;
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LEW = (CFG_LEN_W > RW + 1) ? CFG_LEN_W : RW + 1;
  localparam int CEW = (CFG_CNT_W > CW + 1) ? CFG_CNT_W : CW + 1;

  // Configuration registers
  logic [CFG_MODE_W-1:0] decode_mode_r;
  logic [CFG_LEN_W-1:0]  column_length_r;
  logic [CFG_CNT_W-1:0]  column_count_r;

  // Scan position
  logic [RW-1:0] run_pos_r;
  logic [CW-1:0] col_pos_r;

  // Stage 1 (predict and write back)
  logic          s1_valid_r;
  logic [RW-1:0] s1_y_r;
  logic          s1_first_col_r;
  logic          s1_first_run_pos_r;
  logic          s1_use_diff_r;
  logic          s1_eof_r;
  pix_t          s1_res_r;
  pix_t          s1_prev_r;
  logic          s1_fwd_r;
  pix_t          rd_data_r;

  // Neighbor registers
  pix_t above_r;
  pix_t above_left_r;

  // Output register
  logic out_valid_r;
  pix_t out_pix_r;
  logic out_last_r;

  // Column history RAM
  pix_t hist_mem [MAX_COLUMN_LENGTH];

  logic          in_fire;
  logic          s1_adv;
  logic          s1_fire;
  logic [LEW-1:0] eff_len;
  logic [CEW-1:0] eff_cnt;
  logic          last_in_run;
  logic          last_col;
  logic          use_diff;
  pix_t          left;
  pix_t          grad;
  pix_t          pred;
  pix_t          pix;

  assign cfg_ready = 1'b1;

  // Handshake
  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // Effective length and count, clamped to 1..max
  always_comb begin
    if (column_length_r == '0) begin
      eff_len = LEW'(1);
    end else if (LEW'(column_length_r) > LEW'(MAX_COLUMN_LENGTH)) begin
      eff_len = LEW'(MAX_COLUMN_LENGTH);
    end else begin
      eff_len = LEW'(column_length_r);
    end
    if (column_count_r == '0) begin
      eff_cnt = CEW'(1);
    end else if (CEW'(column_count_r) > CEW'(MAX_COLUMNS)) begin
      eff_cnt = CEW'(MAX_COLUMNS);
    end else begin
      eff_cnt = CEW'(column_count_r);
    end
  end

  assign last_in_run = (LEW'(run_pos_r) + LEW'(1)) >= eff_len;
  assign last_col    = (CEW'(col_pos_r) + CEW'(1)) >= eff_cnt;

  // Mode decode at accept
  always_comb begin
    case (decode_mode_r)
      MODE_DIFF:   use_diff = 1'b1;
      MODE_SELECT: use_diff = in_tuser;
      default:     use_diff = 1'b0;
    endcase
  end

  // Prediction; left comes forwarded when the same entry was written back as this item was read
  assign left = s1_fwd_r ? above_r : rd_data_r;
  assign grad = above_r + left - above_left_r;

  always_comb begin
    if (s1_first_col_r && s1_first_run_pos_r) begin
      pred = '0;
    end else if (s1_first_col_r) begin
      pred = above_r;
    end else if (s1_first_run_pos_r) begin
      pred = left;
    end else begin
      pred = med3(above_r, left, grad);
    end
  end

  assign pix = s1_use_diff_r ? (s1_res_r + s1_prev_r) : (s1_res_r + pred);

  // History RAM: read on accept, write on stage 1 advance
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= hist_mem[run_pos_r];
    end
    if (s1_fire) begin
      hist_mem[s1_y_r] <= pix;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_y_r             <= run_pos_r;
      s1_first_col_r     <= (col_pos_r == '0);
      s1_first_run_pos_r <= (run_pos_r == '0);
      s1_use_diff_r      <= use_diff;
      s1_eof_r           <= last_in_run && last_col;
      s1_res_r           <= in_tdata[7:0];
      s1_prev_r          <= in_tdata[15:8];
    end
    if (s1_fire) begin
      out_pix_r  <= pix;
      out_last_r <= s1_eof_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r   <= MODE_INTRA;
      column_length_r <= RST_COLUMN_LENGTH;
      column_count_r  <= RST_COLUMN_COUNT;
      run_pos_r       <= '0;
      col_pos_r       <= '0;
      s1_valid_r      <= 1'b0;
      s1_fwd_r        <= 1'b0;
      above_r         <= '0;
      above_left_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DECODE_MODE:   decode_mode_r   <= cfg_data[CFG_MODE_W-1:0];
          REG_COLUMN_LENGTH: column_length_r <= cfg_data[CFG_LEN_W-1:0];
          REG_COLUMN_COUNT:  column_count_r  <= cfg_data[CFG_CNT_W-1:0];
          default: ;
        endcase
      end
      // scan position advance
      if (in_fire) begin
        if (last_in_run) begin
          run_pos_r <= '0;
          col_pos_r <= last_col ? '0 : col_pos_r + CW'(1);
        end else begin
          run_pos_r <= run_pos_r + RW'(1);
        end
        s1_fwd_r <= s1_fire && (s1_y_r == run_pos_r);
      end else if (s1_fire) begin
        // stage 1 drains with nothing behind it
        s1_fwd_r <= 1'b0;
      end
      // stage 1 valid
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      // neighbor update
      if (s1_fire) begin
        above_r      <= pix;
        above_left_r <= left;
      end
      // output register
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_valid_r)
    else $error("forward flag set with empty stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv && !in_fire) |=> (s1_valid_r && $stable(s1_y_r)))
    else $error("stalled stage 1 item lost or moved");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("valids not cleared by reset");

  a_fwd_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_fire && (s1_y_r == run_pos_r)) |=> s1_fwd_r)
    else $error("same-entry access not forwarded");

endmodule
